@@ hw/rtl/mf2_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the 2-d median filter
// no dependencies
package mf2_pkg;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int WCFG_W = 11;
  localparam int HCFG_W = 13;
  localparam int RCFG_W = 2;

  localparam logic [WCFG_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [HCFG_W-1:0] HEIGHT_RST = 13'd1024;
  localparam logic [RCFG_W-1:0] RADIUS_RST = 2'd2;
  localparam logic [HCFG_W-1:0] MAX_ROWS   = 13'd4096;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_t;

  // per-request control carried down the pipeline
  typedef struct packed {
    logic              emit;
    logic [ROW_W-1:0]  crow;
    logic [COL_W-1:0]  ccol;
    logic              flast;
    logic [RCFG_W-1:0] r;
  } stage_ctrl_t;

endpackage

@@ hw/rtl/mf2_if.sv @@
`timescale 1ns / 1ps
// channel interfaces of the 2-d median filter: pixel in, result out, config write
// depends on mf2_pkg
interface mf2_pix_if;
  import mf2_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface mf2_res_if;
  import mf2_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] median_value;
  logic [ROW_W-1:0] center_row;
  logic [COL_W-1:0] center_col;
  logic             frame_last;
  modport source (output valid, median_value, center_row, center_col, frame_last,
                  input ready);
  modport sink   (input valid, median_value, center_row, center_col, frame_last,
                  output ready);
endinterface

interface mf2_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/median_filter_2d_unit.sv @@
`timescale 1ns / 1ps
// top level of the 2-d sliding window median filter
// depends on mf2_pkg, mf2_if, mf2_line_store, mf2_cell
//
// Streams 8-bit grey pixels in raster order, one request per clock, and
// returns the median of the (2r+1)x(2r+1) window around each interior pixel
// with its row and column; border pixels give no result. The whole pipeline
// advances together, so one pixel is taken every cycle unless the result
// register is full and not being taken. A request passes line store read,
// window column shift, pairwise compare, rank count and median select, each
// registered. Line store entries have no reset; unwritten ones only feed
// windows with no result, so no clearing pass follows reset. Configuration
// (width, height, radius) is written via the cfg port by the user only while idle, unchecked.
module median_filter_2d_unit
  import mf2_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  mf2_pix_if.sink       in_s,
  mf2_res_if.source     out_s,
  mf2_cfg_if.sink       cfg_s
);
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int LROWS    = 2 * MAX_RADIUS;
  localparam int LI       = $clog2(LROWS);
  localparam int MAX_SIDE = 2 * MAX_RADIUS + 1;
  localparam int N        = MAX_SIDE * MAX_SIDE;
  localparam int RW       = $clog2(N);

  // configuration registers
  logic [WCFG_W-1:0] width_r;
  logic [HCFG_W-1:0] height_r;
  logic [RCFG_W-1:0] radius_r;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      radius_r <= RADIUS_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        CFG_WIDTH:  width_r  <= cfg_s.data[WCFG_W-1:0];
        CFG_HEIGHT: height_r <= cfg_s.data[HCFG_W-1:0];
        CFG_RADIUS: radius_r <= cfg_s.data[RCFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamped working values
  logic [12:0]       w_eff;
  logic [12:0]       h_eff;
  logic [RCFG_W-1:0] r_eff;
  logic [2:0]        two_r;

  always_comb begin
    w_eff = 13'(width_r);
    if (w_eff == 13'd0) w_eff = 13'd1;
    if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    h_eff = height_r;
    if (h_eff == 13'd0) h_eff = 13'd1;
    if (h_eff > MAX_ROWS) h_eff = MAX_ROWS;
    r_eff = (radius_r > RCFG_W'(MAX_RADIUS)) ? RCFG_W'(MAX_RADIUS) : radius_r;
    two_r = {r_eff, 1'b0};
  end

  // pipeline advance: everything moves when the result register can take
  logic out_valid_r;
  logic adv;
  logic in_acc;

  assign adv        = !out_valid_r || out_s.ready;
  assign in_s.ready = adv;
  assign in_acc     = in_s.valid && adv;

  // raster counters
  logic [CW-1:0]    col_count_r, col_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [CW-1:0]    col_base, col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             row_end, frame_end;
  stage_ctrl_t      ctrl_in;

  always_comb begin
    col_base = in_s.frame_start ? '0 : col_count_r;
    row_cur  = in_s.frame_start ? '0 : row_count_r;
    col_cur  = (13'(col_base) >= w_eff) ? '0 : col_base;
    row_end   = (13'(col_cur) + 13'd1 >= w_eff);
    frame_end = row_end && (13'(row_cur) + 13'd1 >= h_eff);

    ctrl_in.emit  = (row_cur >= ROW_W'(two_r)) && (13'(col_cur) >= 13'(two_r));
    ctrl_in.crow  = row_cur - ROW_W'(r_eff);
    ctrl_in.ccol  = COL_W'(col_cur - CW'(r_eff));
    ctrl_in.flast = frame_end;
    ctrl_in.r     = r_eff;

    priority if (frame_end) begin
      col_count_nxt = '0;
      row_count_nxt = '0;
    end else if (row_end) begin
      col_count_nxt = '0;
      row_count_nxt = row_cur + ROW_W'(1);
    end else begin
      col_count_nxt = col_cur + CW'(1);
      row_count_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (in_acc) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // stage 0: line store word for the pixel's column
  logic             v0_r;
  stage_ctrl_t      c0_r;
  logic [PIX_W-1:0] pix0_r;
  logic [CW-1:0]    col0_r;
  logic [LROWS*PIX_W-1:0] line_rd, line_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      c0_r   <= ctrl_in;
      pix0_r <= in_s.pixel;
      col0_r <= col_cur;
    end
  end

  mf2_line_store #(
    .DEPTH  (MAX_WIDTH),
    .WORD_W (LROWS * PIX_W)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (col_cur),
    .wr_en   (adv && v0_r),
    .wr_addr (col0_r),
    .wr_data (line_wr),
    .rd_data (line_rd)
  );

  // rows age by one: newest pixel into row 0
  assign line_wr = {line_rd[(LROWS-1)*PIX_W-1:0], pix0_r};

  // new window column, oldest row first, current pixel at row 2r
  logic [MAX_SIDE-1:0][PIX_W-1:0] new_col;
  logic [LROWS-1:0][PIX_W-1:0]    line_b;
  logic [2:0]                     two_r0;

  assign line_b = line_rd;
  assign two_r0 = {c0_r.r, 1'b0};

  always_comb begin
    for (int a = 0; a < MAX_SIDE; a++) begin
      if (3'(a) == two_r0) begin
        new_col[a] = pix0_r;
      end else if (3'(a) < two_r0) begin
        new_col[a] = line_b[LI'(two_r0 - 3'(a) - 3'd1)];
      end else begin
        new_col[a] = '0;
      end
    end
  end

  // stage 1: chain of column cells, newest column enters at the top cell
  logic        v1_r;
  stage_ctrl_t c1_r;
  logic [MAX_SIDE-1:0][MAX_SIDE-1:0][PIX_W-1:0] cell_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v0_r) begin
      c1_r <= c0_r;
    end
  end

  for (genvar k = 0; k < MAX_SIDE; k++) begin : g_cell
    if (k == MAX_SIDE - 1) begin : g_top
      mf2_cell #(.ROWS(MAX_SIDE)) u_cell (
        .clk      (clk),
        .shift_en (adv && v0_r),
        .col_in   (new_col),
        .col_out  (cell_out[k])
      );
    end else begin : g_mid
      mf2_cell #(.ROWS(MAX_SIDE)) u_cell (
        .clk      (clk),
        .shift_en (adv && v0_r),
        .col_in   (cell_out[k+1]),
        .col_out  (cell_out[k])
      );
    end
  end

  // window positions in use for a given radius
  logic [N-1:0]             act1, act3;
  logic [N-1:0][PIX_W-1:0]  vals1;
  logic [2:0]               two_r1, two_r3;
  logic [N-1:0][N-1:0]      cmp_c;

  assign two_r1 = {c1_r.r, 1'b0};

  always_comb begin
    for (int a = 0; a < MAX_SIDE; a++) begin
      for (int c = 0; c < MAX_SIDE; c++) begin
        vals1[a*MAX_SIDE+c] = cell_out[c][a];
        act1[a*MAX_SIDE+c]  = (3'(a) <= two_r1) &&
                              (4'(c) + 4'(two_r1) >= 4'(MAX_SIDE - 1));
      end
    end
  end

  // ties broken by position so every active element has a distinct rank
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        cmp_c[i][j] = act1[i] && act1[j] &&
                      ((vals1[j] < vals1[i]) || ((vals1[j] == vals1[i]) && (j < i)));
      end
    end
  end

  // stage 2: compare matrix registered
  logic                    v2_r;
  stage_ctrl_t             c2_r;
  logic [N-1:0][N-1:0]     cmp2_r;
  logic [N-1:0][PIX_W-1:0] vals2_r;
  logic [N-1:0][RW-1:0]    rank_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      c2_r    <= c1_r;
      cmp2_r  <= cmp_c;
      vals2_r <= vals1;
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank_c[i] = '0;
      for (int j = 0; j < N; j++) begin
        rank_c[i] = rank_c[i] + RW'(cmp2_r[i][j]);
      end
    end
  end

  // stage 3: ranks registered, pick the element of middle rank
  logic                    v3_r;
  stage_ctrl_t             c3_r;
  logic [N-1:0][RW-1:0]    rank3_r;
  logic [N-1:0][PIX_W-1:0] vals3_r;
  logic [5:0]              mid_rank;
  logic [N-1:0]            sel_hit;
  logic [PIX_W-1:0]        median_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r) begin
      c3_r    <= c2_r;
      rank3_r <= rank_c;
      vals3_r <= vals2_r;
    end
  end

  assign two_r3   = {c3_r.r, 1'b0};
  // middle of (2r+1)^2 sorted values is 2r(r+1)
  assign mid_rank = 6'(c3_r.r) * (6'(c3_r.r) + 6'd1) * 6'd2;

  always_comb begin
    median_c = '0;
    for (int a = 0; a < MAX_SIDE; a++) begin
      for (int c = 0; c < MAX_SIDE; c++) begin
        act3[a*MAX_SIDE+c] = (3'(a) <= two_r3) &&
                             (4'(c) + 4'(two_r3) >= 4'(MAX_SIDE - 1));
      end
    end
    for (int i = 0; i < N; i++) begin
      sel_hit[i] = act3[i] && (6'(rank3_r[i]) == mid_rank);
      if (sel_hit[i]) median_c = median_c | vals3_r[i];
    end
  end

  // result register
  logic [PIX_W-1:0] med_r;
  logic [ROW_W-1:0] crow_r;
  logic [COL_W-1:0] ccol_r;
  logic             flast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r && c3_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v3_r && c3_r.emit) begin
      med_r   <= median_c;
      crow_r  <= c3_r.crow;
      ccol_r  <= c3_r.ccol;
      flast_r <= c3_r.flast;
    end
  end

  assign out_s.valid        = out_valid_r;
  assign out_s.median_value = med_r;
  assign out_s.center_row   = crow_r;
  assign out_s.center_col   = ccol_r;
  assign out_s.frame_last   = flast_r;

  // assertions
  a_rank_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && c3_r.emit) |-> $onehot(sel_hit))
    else $error("median select not unique");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> v0_r)
    else $error("accepted request lost at stage 0");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_s.frame_start && w_eff > 13'd1) |=>
      (col_count_r == CW'(1) && row_count_r == '0))
    else $error("frame start did not restart counters");

endmodule

@@ hw/rtl/mf2_line_store.sv @@
`timescale 1ns / 1ps
// line store: one word per column holding all buffered rows, registered read
// with bypass of the most recent write; depends on mf2_pkg
module mf2_line_store
  import mf2_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int WORD_W = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data,
  output logic [WORD_W-1:0]        rd_data
);
  localparam int AW = $clog2(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q_r;
  logic [AW-1:0]     rd_addr_r;
  logic [AW-1:0]     lw_addr_r;
  logic [WORD_W-1:0] lw_data_r;
  logic              lw_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (wr_en) begin
      lw_addr_r <= wr_addr;
      lw_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (wr_en) begin
      lw_valid_r <= 1'b1;
    end
  end

  // a write on the same edge as the read is not seen by the array
  assign rd_data = (lw_valid_r && lw_addr_r == rd_addr_r) ? lw_data_r : rd_q_r;

endmodule

@@ hw/rtl/mf2_cell.sv @@
`timescale 1ns / 1ps
// one window column cell: takes the column of its upper neighbour on shift
// depends on mf2_pkg
module mf2_cell
  import mf2_pkg::*;
#(
  parameter int ROWS = 5
) (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [ROWS-1:0][PIX_W-1:0] col_in,
  output logic [ROWS-1:0][PIX_W-1:0] col_out
);
  logic [ROWS-1:0][PIX_W-1:0] col_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule
